// File: hw/rtl/push_both_ends_pop_front_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the output-restricted deque
// Clocked implication checks, disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef PUSH_BOTH_ENDS_POP_FRONT_QUEUE_TOP_ASSERT_SVH
`define PUSH_BOTH_ENDS_POP_FRONT_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define PBEPFQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication
`define PBEPFQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// File: hw/rtl/pbepfq_pkg.sv
// ----------------------------------------------------------------------------
// pbepfq_pkg
// Sizes, request and status codes, and the result record of the deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbepfq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int REQ_BITS  = 3;
    localparam int ST_BITS   = 2;

    localparam logic [REQ_BITS-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_PEEK_FRONT = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_TRAVERSE   = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR      = 3'd5;

    localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [ST_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;

    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    typedef struct packed {
        logic [ST_BITS-1:0]   status;
        logic [WORD_BITS-1:0] word;
        logic                 last;
        logic [CNT_BITS-1:0]  count;
    } result_t;

    function automatic logic [IDX_BITS-1:0] next_slot(input logic [IDX_BITS-1:0] i);
        logic [IDX_BITS-1:0] r;
        if (i == IDX_BITS'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [IDX_BITS-1:0] prev_slot(input logic [IDX_BITS-1:0] i);
        logic [IDX_BITS-1:0] r;
        if (i == '0)
        begin
            r = IDX_BITS'(DEPTH - 1);
        end
        else
        begin
            r = i - 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pbepfq_ram.sv
// ----------------------------------------------------------------------------
// pbepfq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbepfq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pbepfq_obuf.sv
// ----------------------------------------------------------------------------
// pbepfq_obuf
// Output register: holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbepfq_obuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire pbepfq_pkg::result_t res_in,
    output logic                   ready,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output pbepfq_pkg::result_t    res_out
);

    logic                valid_reg;
    logic                valid_next;
    pbepfq_pkg::result_t res_reg;

    assign ready     = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/push_both_ends_pop_front_queue_top.sv
// ----------------------------------------------------------------------------
// push_both_ends_pop_front_queue_top
// Output-restricted deque of 16 words held in a ring memory.
// ----------------------------------------------------------------------------
// One request at a time. A push, and a pop or peek of an empty store, load their
// result at once; a pop or peek of a stored word passes through a read state, as
// the front word comes out of the ring memory in the cycle after its read.
// Traverse and clear with release give one result per stored word: the single
// read port of the ring memory delivers one word per cycle while the output is
// not stalled. A clear without release or of an empty store, a traverse of an
// empty store and an unknown request give no result. Results wait in an output
// register; a stalled output holds the next request back.
`timescale 1ns / 1ps
`default_nettype none

module push_both_ends_pop_front_queue_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pbepfq_pkg::REQ_BITS-1:0]   req_type,
    input  wire logic [pbepfq_pkg::WORD_BITS-1:0]  push_word,
    input  wire logic                              release_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [pbepfq_pkg::ST_BITS-1:0]    status,
    output logic      [pbepfq_pkg::WORD_BITS-1:0]  out_word,
    output logic                                   last_of_run,
    output logic      [pbepfq_pkg::CNT_BITS-1:0]   count_now
);

`include "push_both_ends_pop_front_queue_top_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;
    logic [pbepfq_pkg::IDX_BITS-1:0]   front_reg;
    logic [pbepfq_pkg::IDX_BITS-1:0]   front_next;
    logic [pbepfq_pkg::IDX_BITS-1:0]   back_reg;
    logic [pbepfq_pkg::IDX_BITS-1:0]   back_next;
    logic [pbepfq_pkg::CNT_BITS-1:0]   count_reg;
    logic [pbepfq_pkg::CNT_BITS-1:0]   count_next;
    logic [pbepfq_pkg::IDX_BITS-1:0]   walk_reg;
    logic [pbepfq_pkg::IDX_BITS-1:0]   walk_next;
    logic [pbepfq_pkg::CNT_BITS-1:0]   remain_reg;
    logic [pbepfq_pkg::CNT_BITS-1:0]   remain_next;
    logic                              pop_reg;
    logic                              pop_next;
    logic                              clr_reg;
    logic                              clr_next;

    logic                              in_accept;
    logic                              obuf_ready;
    logic                              res_load;
    pbepfq_pkg::result_t               res;
    pbepfq_pkg::result_t               res_out;

    logic                              wr_en;
    logic [pbepfq_pkg::IDX_BITS-1:0]   wr_addr;
    logic                              rd_en;
    logic [pbepfq_pkg::IDX_BITS-1:0]   rd_addr;
    logic [pbepfq_pkg::WORD_BITS-1:0]  rd_data;

    assign in_stall  = !((state_reg == S_IDLE) && obuf_ready);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        remain_next = remain_reg;
        pop_next    = pop_reg;
        clr_next    = clr_reg;
        res_load    = 1'b0;
        res         = '0;
        wr_en       = 1'b0;
        wr_addr     = back_reg;
        rd_en       = 1'b0;
        rd_addr     = front_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (req_type)
                        pbepfq_pkg::REQ_PUSH_FRONT, pbepfq_pkg::REQ_PUSH_BACK:
                        begin
                            res_load = 1'b1;
                            if (count_reg == pbepfq_pkg::CNT_FULL)
                            begin
                                res.status = pbepfq_pkg::ST_FULL;
                                res.last   = 1'b1;
                                res.count  = count_reg;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (req_type == pbepfq_pkg::REQ_PUSH_FRONT)
                                begin
                                    wr_addr    = pbepfq_pkg::prev_slot(front_reg);
                                    front_next = pbepfq_pkg::prev_slot(front_reg);
                                end
                                else
                                begin
                                    wr_addr   = back_reg;
                                    back_next = pbepfq_pkg::next_slot(back_reg);
                                end
                                count_next = count_reg + 1'b1;
                                res.status = pbepfq_pkg::ST_OK;
                                res.last   = 1'b1;
                                res.count  = count_reg + 1'b1;
                            end
                        end
                        pbepfq_pkg::REQ_POP_FRONT, pbepfq_pkg::REQ_PEEK_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res.status = pbepfq_pkg::ST_EMPTY;
                                res.last   = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = front_reg;
                                pop_next   = (req_type == pbepfq_pkg::REQ_POP_FRONT);
                                state_next = S_READ;
                            end
                        end
                        pbepfq_pkg::REQ_TRAVERSE:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = front_reg;
                                walk_next   = front_reg;
                                remain_next = count_reg;
                                clr_next    = 1'b0;
                                state_next  = S_WALK;
                            end
                        end
                        pbepfq_pkg::REQ_CLEAR:
                        begin
                            if (release_data && (count_reg != '0))
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = front_reg;
                                walk_next   = front_reg;
                                remain_next = count_reg;
                                clr_next    = 1'b1;
                                state_next  = S_WALK;
                            end
                            else
                            begin
                                front_next = '0;
                                back_next  = '0;
                                count_next = '0;
                                walk_next  = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (obuf_ready)
                begin
                    res_load   = 1'b1;
                    res.status = pbepfq_pkg::ST_OK;
                    res.word   = rd_data;
                    res.last   = 1'b1;
                    res.count  = count_reg;
                    if (pop_reg)
                    begin
                        front_next = pbepfq_pkg::next_slot(front_reg);
                        count_next = count_reg - 1'b1;
                        res.count  = count_reg - 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (obuf_ready)
                begin
                    res_load   = 1'b1;
                    res.status = pbepfq_pkg::ST_OK;
                    res.word   = rd_data;
                    res.last   = (remain_reg == pbepfq_pkg::CNT_BITS'(1));
                    res.count  = clr_reg ? '0 : count_reg;
                    if (remain_reg == pbepfq_pkg::CNT_BITS'(1))
                    begin
                        state_next = S_IDLE;
                        if (clr_reg)
                        begin
                            front_next = '0;
                            back_next  = '0;
                            count_next = '0;
                            walk_next  = '0;
                        end
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = pbepfq_pkg::next_slot(walk_reg);
                        walk_next   = pbepfq_pkg::next_slot(walk_reg);
                        remain_next = remain_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            walk_reg   <= '0;
            remain_reg <= '0;
            pop_reg    <= 1'b0;
            clr_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            walk_reg   <= walk_next;
            remain_reg <= remain_next;
            pop_reg    <= pop_next;
            clr_reg    <= clr_next;
        end
    end

    pbepfq_ram #(
        .DEPTH (pbepfq_pkg::DEPTH),
        .WIDTH (pbepfq_pkg::WORD_BITS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pbepfq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res_in    (res),
        .ready     (obuf_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign status      = res_out.status;
    assign out_word    = res_out.word;
    assign last_of_run = res_out.last;
    assign count_now   = res_out.count;

    `PBEPFQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= pbepfq_pkg::CNT_FULL)
    `PBEPFQ_ASSERT_IMP(a_ring_span, clk, rst_n, 1'b1,
        (back_reg - front_reg) == count_reg[pbepfq_pkg::IDX_BITS-1:0])
    `PBEPFQ_ASSERT_IMP(a_walk_remain, clk, rst_n, state_reg == S_WALK,
        (remain_reg != '0) && (remain_reg <= count_reg))
    `PBEPFQ_ASSERT_NXT(a_push_grows, clk, rst_n,
        in_accept && (count_reg != pbepfq_pkg::CNT_FULL) &&
        ((req_type == pbepfq_pkg::REQ_PUSH_FRONT) || (req_type == pbepfq_pkg::REQ_PUSH_BACK)),
        count_reg == ($past(count_reg) + 1'b1))

endmodule

`default_nettype wire
